// ----- src/pressure_sensor_compensation_defines.svh -----
// ----------------------------------------------------------------------------
// Pressure sensor compensation assertion macros
// Shared concurrent assertion forms used by the compensation datapath.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH

// check on the same edge
`define PSC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// check on the following edge
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- src/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// Pressure sensor compensation package
// Register indexes, coefficients, pipeline depths and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

   localparam logic [2:0] REG_CAL_FIRST    = 3'd0;
   localparam logic [2:0] REG_CAL_UNSIGNED = 3'd1;
   localparam logic [2:0] REG_CAL_B        = 3'd2;
   localparam logic [2:0] REG_CAL_M        = 3'd3;
   localparam logic [2:0] REG_OVERSAMPLING = 3'd4;

   localparam logic [31:0] K_3038  = 32'd3038;
   localparam logic [31:0] K_7357  = 32'd7357;
   localparam logic [31:0] K_3791  = 32'd3791;
   localparam logic [31:0] K_4000  = 32'd4000;
   localparam logic [31:0] K_50000 = 32'd50000;
   localparam logic [31:0] K_32768 = 32'd32768;

   localparam int DIV1_NUM_W = 27;
   localparam int DIV1_DEN_W = 32;
   localparam int DIV2_NUM_W = 32;
   localparam int DIV2_DEN_W = 17;
   localparam int PIPE_DEPTH = 4 + DIV1_NUM_W + 9 + DIV2_NUM_W + 6;

   typedef struct packed {
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        fz;
   } d1_type;

   typedef struct packed {
      logic [15:0] temp;
      logic        fz;
   } tag_type;

   typedef struct packed {
      tag_type tag;
      logic    pz;
      logic    hi;
   } d2_type;

endpackage

`default_nettype wire

// ----- src/pressure_sensor_compensation.sv -----
// The path from input transfer to result runs through the 27-stage and
// 32-stage divider pipelines plus 19 arithmetic stages.
// Throughput: one sample per cycle; a stalled output holds the whole pipeline.
// Reset clears the valid bits and calibration registers; payload is not reset.
// ----------------------------------------------------------------------------
// Pressure sensor compensation
// Computes compensated temperature and pressure from raw sensor words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pressure_sensor_compensation_defines.svh"

module pressure_sensor_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // raw_temperature, raw_pressure
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // temperature_tenths, pressure_pa, divide_fault
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   localparam int L = psc_pkg::PIPE_DEPTH;

   logic [47:0] cal_f_ff, cal_u_ff;
   logic [31:0] cal_b_ff, cal_m_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_f_ff <= '0;
         cal_u_ff <= '0;
         cal_b_ff <= '0;
         cal_m_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            psc_pkg::REG_CAL_FIRST:    cal_f_ff <= csr_wdata;
            psc_pkg::REG_CAL_UNSIGNED: cal_u_ff <= csr_wdata;
            psc_pkg::REG_CAL_B:        cal_b_ff <= csr_wdata[31:0];
            psc_pkg::REG_CAL_M:        cal_m_ff <= csr_wdata[31:0];
            psc_pkg::REG_OVERSAMPLING: oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_f_ff[15]}}, cal_f_ff[15:0]};
   assign ac2 = {{16{cal_f_ff[31]}}, cal_f_ff[31:16]};
   assign ac3 = {{16{cal_f_ff[47]}}, cal_f_ff[47:32]};
   assign ac4 = {16'b0, cal_u_ff[15:0]};
   assign ac5 = {16'b0, cal_u_ff[31:16]};
   assign ac6 = {16'b0, cal_u_ff[47:32]};
   assign b1  = {{16{cal_b_ff[15]}}, cal_b_ff[15:0]};
   assign b2  = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
   assign mc  = {{16{cal_m_ff[15]}}, cal_m_ff[15:0]};
   assign md  = {{16{cal_m_ff[31]}}, cal_m_ff[31:16]};

   logic         en;
   logic [L-1:0] vld_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[L-2:0], req_tvalid};
      end
   end

   // front stages
   logic [31:0] s1_d_ff, s2_m_ff, s3_x1_ff, s3_den_ff;
   logic [18:0] s1_up_ff, s2_up_ff, s3_up_ff;
   logic [26:0] s4_nmag_ff;
   logic [31:0] s4_dmag_ff;
   psc_pkg::d1_type s4_ff;
   psc_pkg::d1_type d1_ff [psc_pkg::DIV1_NUM_W];
   logic [31:0] x1_s2, a_mc, a_neg_val;
   logic [26:0] quo1;

   assign x1_s2     = $unsigned($signed(s2_m_ff) >>> 15);
   assign a_mc      = {mc[20:0], 11'b0};
   assign a_neg_val = 32'd0 - a_mc;

   // middle stages
   logic [31:0] s5_b5_ff, s6_b6_ff, s7_b6b6_ff, s7_ac2b6_ff, s7_ac3b6_ff;
   logic [31:0] s8_b2sq_ff, s8_b1sq_ff, s8_ac2b6_ff, s8_ac3b6_ff;
   logic [31:0] s9_x3a_ff, s9_x3b_ff, s10_b3_ff, s10_b4arg_ff;
   logic [31:0] s11_b4p_ff, s11_diff_ff, s12_b7_ff, s13_num_ff;
   logic [16:0] s12_b4_ff, s13_den_ff;
   logic [18:0] s5_up_ff, s6_up_ff, s7_up_ff, s8_up_ff, s9_up_ff, s10_up_ff;
   logic        s5_fz_ff;
   psc_pkg::tag_type s6_ff, s7_ff, s8_ff, s9_ff, s10_ff, s11_ff, s12_ff;
   psc_pkg::d2_type  s13_ff;
   psc_pkg::d2_type  d2_ff [psc_pkg::DIV2_NUM_W];
   logic [31:0] qx1, x2_s4, tq_s5, sq_s7, b3_pre, x3b_pre;
   logic [15:0] temp_in;
   logic [31:0] quo2;

   assign qx1    = {5'b0, quo1};
   assign x2_s4  = d1_ff[psc_pkg::DIV1_NUM_W-1].neg ? 32'd0 - qx1 : qx1;
   assign tq_s5  = $unsigned($signed(s5_b5_ff + 32'd8) >>> 4);
   assign sq_s7  = $unsigned($signed(s7_b6b6_ff) >>> 12);
   assign b3_pre = ({ac1[29:0], 2'b0} + s9_x3a_ff) << oss_ff;
   assign x3b_pre = $unsigned($signed(s8_ac3b6_ff) >>> 13)
                  + $unsigned($signed(s8_b1sq_ff) >>> 16) + 32'd2;

   always_comb begin
      if ($signed(tq_s5) > 32'sd32767) begin
         temp_in = 16'h7FFF;
      end else if ($signed(tq_s5) < -32'sd32768) begin
         temp_in = 16'h8000;
      end else begin
         temp_in = tq_s5[15:0];
      end
   end

   // back stages
   logic [31:0] s14_p_ff, s15_phph_ff, s15_m7_ff, s15_p_ff, s16_a_ff, s16_x2_ff, s16_p_ff;
   logic [31:0] s17_s_ff, s17_p_ff, s18_p_ff;
   psc_pkg::d2_type s14_ff, s15_ff, s16_ff, s17_ff, s18_ff;
   logic [31:0] ph_s14;
   logic [15:0] rsp_temp_ff;
   logic [19:0] rsp_press_ff, press_in;
   logic        rsp_fault_ff;

   assign ph_s14 = $unsigned($signed(s14_p_ff) >>> 8);

   always_comb begin
      if ($signed(s18_p_ff) < 32'sd0) begin
         press_in = '0;
      end else if ($signed(s18_p_ff) > 32'sd1048575) begin
         press_in = 20'hFFFFF;
      end else begin
         press_in = s18_p_ff[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d_ff  <= {16'b0, req_tdata[15:0]} - ac6;
         s1_up_ff <= req_tdata[34:16];

         s2_m_ff  <= s1_d_ff * ac5;
         s2_up_ff <= s1_up_ff;

         s3_x1_ff  <= x1_s2;
         s3_den_ff <= x1_s2 + md;
         s3_up_ff  <= s2_up_ff;

         s4_nmag_ff <= mc[15] ? a_neg_val[26:0] : a_mc[26:0];
         s4_dmag_ff <= s3_den_ff[31] ? 32'd0 - s3_den_ff : s3_den_ff;
         s4_ff.x1   <= s3_x1_ff;
         s4_ff.up   <= s3_up_ff;
         s4_ff.neg  <= mc[15] ^ s3_den_ff[31];
         s4_ff.fz   <= s3_den_ff == 32'd0;

         d1_ff[0] <= s4_ff;
         for (int i = 1; i < psc_pkg::DIV1_NUM_W; i++) begin
            d1_ff[i] <= d1_ff[i-1];
         end

         s5_b5_ff <= d1_ff[psc_pkg::DIV1_NUM_W-1].x1 + x2_s4;
         s5_up_ff <= d1_ff[psc_pkg::DIV1_NUM_W-1].up;
         s5_fz_ff <= d1_ff[psc_pkg::DIV1_NUM_W-1].fz;

         s6_b6_ff   <= s5_b5_ff - psc_pkg::K_4000;
         s6_ff.temp <= temp_in;
         s6_ff.fz   <= s5_fz_ff;
         s6_up_ff   <= s5_up_ff;

         s7_b6b6_ff  <= s6_b6_ff * s6_b6_ff;
         s7_ac2b6_ff <= ac2 * s6_b6_ff;
         s7_ac3b6_ff <= ac3 * s6_b6_ff;
         s7_ff       <= s6_ff;
         s7_up_ff    <= s6_up_ff;

         s8_b2sq_ff  <= b2 * sq_s7;
         s8_b1sq_ff  <= b1 * sq_s7;
         s8_ac2b6_ff <= s7_ac2b6_ff;
         s8_ac3b6_ff <= s7_ac3b6_ff;
         s8_ff       <= s7_ff;
         s8_up_ff    <= s7_up_ff;

         s9_x3a_ff <= $unsigned($signed(s8_b2sq_ff) >>> 11)
                    + $unsigned($signed(s8_ac2b6_ff) >>> 11);
         s9_x3b_ff <= $unsigned($signed(x3b_pre) >>> 2);
         s9_ff     <= s8_ff;
         s9_up_ff  <= s8_up_ff;

         s10_b3_ff    <= $unsigned($signed(b3_pre + 32'd2) >>> 2);
         s10_b4arg_ff <= s9_x3b_ff + psc_pkg::K_32768;
         s10_ff       <= s9_ff;
         s10_up_ff    <= s9_up_ff;

         s11_b4p_ff  <= ac4 * s10_b4arg_ff;
         s11_diff_ff <= {13'b0, s10_up_ff} - s10_b3_ff;
         s11_ff      <= s10_ff;

         s12_b4_ff <= s11_b4p_ff[31:15];
         s12_b7_ff <= s11_diff_ff * (psc_pkg::K_50000 >> oss_ff);
         s12_ff    <= s11_ff;

         s13_num_ff  <= s12_b7_ff[31] ? s12_b7_ff : {s12_b7_ff[30:0], 1'b0};
         s13_den_ff  <= s12_b4_ff;
         s13_ff.tag  <= s12_ff;
         s13_ff.pz   <= s12_b4_ff == '0;
         s13_ff.hi   <= s12_b7_ff[31];

         d2_ff[0] <= s13_ff;
         for (int i = 1; i < psc_pkg::DIV2_NUM_W; i++) begin
            d2_ff[i] <= d2_ff[i-1];
         end

         s14_p_ff <= d2_ff[psc_pkg::DIV2_NUM_W-1].hi ? {quo2[30:0], 1'b0} : quo2;
         s14_ff   <= d2_ff[psc_pkg::DIV2_NUM_W-1];

         s15_phph_ff <= ph_s14 * ph_s14;
         s15_m7_ff   <= psc_pkg::K_7357 * s14_p_ff;
         s15_p_ff    <= s14_p_ff;
         s15_ff      <= s14_ff;

         s16_a_ff  <= s15_phph_ff * psc_pkg::K_3038;
         s16_x2_ff <= $unsigned($signed(32'd0 - s15_m7_ff) >>> 16);
         s16_p_ff  <= s15_p_ff;
         s16_ff    <= s15_ff;

         s17_s_ff <= $unsigned($signed(s16_a_ff) >>> 16) + s16_x2_ff + psc_pkg::K_3791;
         s17_p_ff <= s16_p_ff;
         s17_ff   <= s16_ff;

         s18_p_ff <= s17_p_ff + $unsigned($signed(s17_s_ff) >>> 4);
         s18_ff   <= s17_ff;

         rsp_temp_ff  <= s18_ff.tag.fz ? 16'd0 : s18_ff.tag.temp;
         rsp_press_ff <= (s18_ff.tag.fz || s18_ff.pz) ? 20'd0 : press_in;
         rsp_fault_ff <= s18_ff.tag.fz || s18_ff.pz;
      end
   end

   psc_div #(
      .NUM_W(psc_pkg::DIV1_NUM_W),
      .DEN_W(psc_pkg::DIV1_DEN_W)
   ) u_div_temp (
      .clock(clock),
      .en   (en),
      .num  (s4_nmag_ff),
      .den  (s4_dmag_ff),
      .quo  (quo1)
   );

   psc_div #(
      .NUM_W(psc_pkg::DIV2_NUM_W),
      .DEN_W(psc_pkg::DIV2_DEN_W)
   ) u_div_press (
      .clock(clock),
      .en   (en),
      .num  (s13_num_ff),
      .den  (s13_den_ff),
      .quo  (quo2)
   );

   assign rsp_tdata = {3'b0, rsp_fault_ff, rsp_press_ff, rsp_temp_ff};

   `PSC_ASSERT_NEXT(a_hold_on_stall, !en, $stable(vld_ff))
   `PSC_ASSERT_NEXT(a_enter_stage, en && req_tvalid, vld_ff[0])
   `PSC_ASSERT_NOW(a_fault_zero_press, rsp_tvalid && rsp_fault_ff, rsp_press_ff == 20'd0)
   `PSC_ASSERT_NEXT(a_temp_fault_out, en && s18_ff.tag.fz, rsp_temp_ff == 16'd0 && rsp_fault_ff)

endmodule

`default_nettype wire

// ----- src/psc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quo
);

   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] dv_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [NUM_W-1:0] nq_src;
      logic [DEN_W-1:0] rem_src;
      logic [DEN_W-1:0] dv_src;
      logic [DEN_W:0]   trial;
      logic             fit;
      logic [NUM_W-1:0] nq_in;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign nq_src  = num;
         assign rem_src = '0;
         assign dv_src  = den;
      end else begin : g_next
         assign nq_src  = nq_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign dv_src  = dv_ff[k-1];
      end

      assign trial  = {rem_src, nq_src[NUM_W-1]};
      assign fit    = trial >= {1'b0, dv_src};
      assign rem_in = fit ? DEN_W'(trial - {1'b0, dv_src}) : trial[DEN_W-1:0];
      assign nq_in  = {nq_src[NUM_W-2:0], fit};

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k]  <= nq_in;
            rem_ff[k] <= rem_in;
            dv_ff[k]  <= dv_src;
         end
      end
   end

   assign quo = nq_ff[NUM_W-1];

endmodule

`default_nettype wire

// ----- verif/pressure_sensor_compensation_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pressure sensor compensation testbench
// Drives raw temperature/pressure pairs under several calibration sets,
// predicts or lists each compensated result in the bench and compares every transfer
// in order, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_compensation_tb;

   localparam int LATENCY   = 78;
   localparam int MAX_CYCLE = 2000000;

   typedef struct packed {
      logic [15:0] temp;
      logic [19:0] pres;
      logic        fault;
   } comp_result_type;

   typedef struct {
      logic [15:0] ut;
      logic [18:0] up;
      logic        typed;
      comp_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;

   logic [47:0] cal_first, cal_uns;
   logic [31:0] cal_b, cal_m;
   logic [1:0]  oss;

   comp_result_type expected_results[$];
   int mismatches = 0;
   int cycle_count;
   bit stim_done;
   bit hold_off;

   pressure_sensor_compensation u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(logic [31:0] v, int s);
      return $signed(v) >>> s;
   endfunction

   function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
      longint q;
      q = longint'($signed(a)) / longint'($signed(b));
      return q[31:0];
   endfunction

   function automatic comp_result_type compensate(logic [15:0] ut_in, logic [18:0] up_in);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, ph, tw;
      comp_result_type r;
      ac1 = sx16(cal_first[15:0]);
      ac2 = sx16(cal_first[31:16]);
      ac3 = sx16(cal_first[47:32]);
      ac4 = {16'd0, cal_uns[15:0]};
      ac5 = {16'd0, cal_uns[31:16]};
      ac6 = {16'd0, cal_uns[47:32]};
      b1 = sx16(cal_b[15:0]);
      b2 = sx16(cal_b[31:16]);
      mc = sx16(cal_m[15:0]);
      md = sx16(cal_m[31:16]);
      ut = {16'd0, ut_in};
      up = {13'd0, up_in};
      r = '0;
      x1 = asr((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
         r.fault = 1'b1;
         return r;
      end
      x2 = sdiv(mc << 11, den);
      b5 = x1 + x2;
      tw = asr(b5 + 32'd8, 4);
      if ($signed(tw) > 32767) r.temp = 16'h7fff;
      else if ($signed(tw) < -32768) r.temp = 16'h8000;
      else r.temp = tw[15:0];
      b6 = b5 - psc_pkg::K_4000;
      sq = asr(b6 * b6, 12);
      x3 = asr(b2 * sq, 11) + asr(ac2 * b6, 11);
      b3 = asr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x3 = asr(asr(ac3 * b6, 13) + asr(b1 * sq, 16) + 32'd2, 2);
      b4 = (ac4 * (x3 + psc_pkg::K_32768)) >> 15;
      b7 = (up - b3) * (psc_pkg::K_50000 >> oss);
      if (b4 == 0) begin
         r.fault = 1'b1;
         return r;
      end
      if (b7 < 32'h80000000) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      ph = asr(p, 8);
      x1 = asr((ph * ph) * psc_pkg::K_3038, 16);
      x2 = asr(32'd0 - psc_pkg::K_7357 * p, 16);
      p = p + asr(x1 + x2 + psc_pkg::K_3791, 4);
      if ($signed(p) < 0) r.pres = 20'd0;
      else if ($signed(p) > 1048575) r.pres = 20'hfffff;
      else r.pres = p[19:0];
      return r;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_sample(logic [15:0] ut, logic [18:0] up, bit typed,
                              comp_result_type want);
      comp_result_type pred;
      pred = compensate(ut, up);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, up, ut};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(typed ? want : pred);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         psc_pkg::REG_CAL_FIRST:    cal_first = val;
         psc_pkg::REG_CAL_UNSIGNED: cal_uns = val;
         psc_pkg::REG_CAL_B:        cal_b = val[31:0];
         psc_pkg::REG_CAL_M:        cal_m = val[31:0];
         psc_pkg::REG_OVERSAMPLING: oss = val[1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // typical factory calibration set
   task automatic load_typical(logic [1:0] o);
      write_reg(psc_pkg::REG_CAL_FIRST, {16'hc7f5, 16'hfbd8, 16'h1f8c});
      write_reg(psc_pkg::REG_CAL_UNSIGNED, {16'h4b46, 16'h6356, 16'h8568});
      write_reg(psc_pkg::REG_CAL_B, {16'h0028, 16'h1953});
      write_reg(psc_pkg::REG_CAL_M, {16'h0b44, 16'hd4bd});
      write_reg(psc_pkg::REG_OVERSAMPLING, {46'd0, o});
   endtask

   task automatic load_random();
      write_reg(psc_pkg::REG_CAL_FIRST, 48'({$urandom, $urandom}));
      write_reg(psc_pkg::REG_CAL_UNSIGNED, 48'({$urandom, $urandom}));
      write_reg(psc_pkg::REG_CAL_B, {16'd0, $urandom});
      write_reg(psc_pkg::REG_CAL_M, {16'd0, $urandom});
      write_reg(psc_pkg::REG_OVERSAMPLING, 48'($urandom_range(0, 3)));
      // unknown index: ignored
      write_reg(3'd5 + 3'($urandom_range(0, 2)), 48'({$urandom, $urandom}));
   endtask

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         send_sample(16'($urandom), 19'($urandom), 1'b0, '0);
         idle_gap();
      end
   endtask

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cal_first = '0;
      cal_uns = '0;
      cal_b = '0;
      cal_m = '0;
      oss = '0;
      stim_done = 0;
      hold_off = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every word is zero: temperature divisor is zero
      row = '{16'h0000, 19'h00000, 1'b1, '{16'd0, 20'd0, 1'b1}}; rows.push_back(row);
      row = '{16'hffff, 19'h7ffff, 1'b1, '{16'd0, 20'd0, 1'b1}}; rows.push_back(row);
      foreach (rows[i]) send_sample(rows[i].ut, rows[i].up, 1'b1, rows[i].want);
      drain();

      // MC set, AC4 zero: temperature is valid, pressure divisor is zero
      write_reg(psc_pkg::REG_CAL_M, 48'h0001_0000 | 48'h0000_0100);
      rows.delete();
      row = '{16'h1234, 19'h12345, 1'b0, '0}; rows.push_back(row);
      row = '{16'hffff, 19'h7ffff, 1'b0, '0}; rows.push_back(row);
      foreach (rows[i]) send_sample(rows[i].ut, rows[i].up, 1'b0, rows[i].want);
      drain();

      for (int o = 0; o < 4; o++) begin
         load_typical(o[1:0]);
         rows.delete();
         row = '{16'd27898, 19'd23843 << o, 1'b0, '0}; rows.push_back(row);
         row = '{16'h0000, 19'h00000, 1'b0, '0}; rows.push_back(row);
         row = '{16'hffff, 19'h7ffff, 1'b0, '0}; rows.push_back(row);
         row = '{16'h8000, 19'h40000, 1'b0, '0}; rows.push_back(row);
         row = '{16'h4b46, 19'h0ffff, 1'b0, '0}; rows.push_back(row);
         foreach (rows[i]) send_sample(rows[i].ut, rows[i].up, 1'b0, rows[i].want);
         drain();
      end

      // extreme calibration words
      write_reg(psc_pkg::REG_CAL_FIRST, 48'hffff_ffff_ffff);
      write_reg(psc_pkg::REG_CAL_UNSIGNED, 48'hffff_ffff_ffff);
      write_reg(psc_pkg::REG_CAL_B, 48'h7fff_8000);
      write_reg(psc_pkg::REG_CAL_M, 48'h8000_7fff);
      write_reg(psc_pkg::REG_OVERSAMPLING, 48'd3);
      send_sample(16'hffff, 19'h7ffff, 1'b0, '0);
      send_sample(16'h0000, 19'h00000, 1'b0, '0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 2 == 0) load_typical(2'($urandom_range(0, 3)));
         else load_random();
         if (ph == 1) hold_off = 1;
         random_run(125);
         drain();
      end
      stim_done = 1;
   end

   // output side: random stalls plus one long hold-off
   initial begin
      int n;
      bit held;
      rsp_tready = 1'b0;
      held = 0;
      forever begin
         if (hold_off && !held) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) n = 0;
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      comp_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[35:16], rsp_tdata[36]};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("temp exp %h act %h, pres exp %h act %h, fault exp %b act %b",
                           want.temp, got.temp, want.pres, got.pres, want.fault, got.fault);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (!stim_done && cycle_count < MAX_CYCLE) begin
         @(posedge clock);
         cycle_count++;
      end
      if (!stim_done) begin
         $display("pressure_sensor_compensation: mismatch");
      end else begin
         if (mismatches == 0 && expected_results.size() == 0)
            $display("pressure_sensor_compensation: match");
         else
            $display("pressure_sensor_compensation: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
